// ----- src/smap_pkg.sv -----
package smap_pkg;

   localparam logic [15:0] PORT_MASK  = 16'h2112;
   localparam logic [31:0] COOKIE     = 32'h2112_A442;
   localparam logic [16:0] HEADER_LEN = 17'd20;
   localparam logic [16:0] POS_SAT    = 17'h1_FFFF;

   // configuration register indexes
   localparam logic [1:0] CSR_ID_UPPER  = 2'd0;
   localparam logic [1:0] CSR_ID_LOWER  = 2'd1;
   localparam logic [1:0] CSR_ATTR_CODE = 2'd2;
   localparam logic [1:0] CSR_SUCCESS   = 2'd3;

   typedef enum logic [2:0] {
      OUTCOME_OK              = 3'd0,
      OUTCOME_ID_MISMATCH     = 3'd1,
      OUTCOME_NOT_SUCCESS     = 3'd2,
      OUTCOME_UNKNOWN_FAMILY  = 3'd3,
      OUTCOME_LENGTH_MISMATCH = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      FAMILY_NONE = 2'd0,
      FAMILY_IPV4 = 2'd1,
      FAMILY_IPV6 = 2'd2
   } family_type;

   typedef struct packed {
      logic [31:0] id_upper;
      logic [63:0] id_lower;
      logic [15:0] attr_code;
      logic [15:0] success_type;
   } cfg_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } word_type;

   typedef struct packed {
      outcome_type outcome;
      family_type  family;
      logic [15:0] port;
      logic [63:0] addr_high;
      logic [63:0] addr_low;
   } result_type;

endpackage

// ----- src/smap_in_stage.sv -----
module smap_in_stage
   import smap_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  word_type in_word,
   input  logic     advance,
   output logic     out_valid,
   output word_type out_word
);

   logic     valid_ff;
   logic     valid_in;
   word_type word_ff;
   logic     load;

   assign in_ready = !valid_ff || advance;
   assign load     = in_valid && in_ready;
   assign valid_in = load ? 1'b1 : (advance ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= in_word;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

// ----- src/smap_parser.sv -----
module smap_parser
   import smap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  word_type   word,
   output result_type result
);

   logic [16:0] pos_ff,       pos_in;
   logic [15:0] body_len_ff,  body_len_in;
   logic [15:0] msg_kind_ff,  msg_kind_in;
   logic        id_match_ff,  id_match_in;
   logic [15:0] attr_kind_ff, attr_kind_in;
   logic [15:0] attr_len_ff,  attr_len_in;
   logic [16:0] attr_off_ff,  attr_off_in;
   family_type  family_ff,    family_in;
   logic [15:0] port_ff,      port_in;
   logic [63:0] addr_hi_ff,   addr_hi_in;
   logic [63:0] addr_lo_ff,   addr_lo_in;
   logic        bad_fam_ff,   bad_fam_in;

   logic [95:0] id_all;
   logic [4:0]  id_sel;
   logic [7:0]  id_want;
   logic [16:0] value_idx;
   logic [15:0] attr_len_now;
   logic [16:0] len_round;
   logic [2:0]  lane;
   logic [7:0]  b;
   logic        in_header;
   logic        in_body;

   assign b      = word.data;
   assign id_all = {cfg.id_upper, cfg.id_lower};
   assign id_sel = 5'd19 - pos_ff[4:0];
   assign id_want = id_all[{id_sel[3:0], 3'b000} +: 8];
   assign in_header = pos_ff < HEADER_LEN;
   assign in_body   = !in_header && (pos_ff < (HEADER_LEN + {1'b0, body_len_ff}));
   assign value_idx = attr_off_ff - 17'd4;
   // length as it stands after this byte; the low length byte lands at offset 3
   assign attr_len_now = (attr_off_ff == 17'd3) ? {attr_len_ff[7:0], b} : attr_len_ff;
   assign len_round = ({1'b0, attr_len_now} + 17'd3) & ~17'd3;

   always_comb begin
      pos_in       = pos_ff;
      body_len_in  = body_len_ff;
      msg_kind_in  = msg_kind_ff;
      id_match_in  = id_match_ff;
      attr_kind_in = attr_kind_ff;
      attr_len_in  = attr_len_ff;
      attr_off_in  = attr_off_ff;
      family_in    = family_ff;
      port_in      = port_ff;
      addr_hi_in   = addr_hi_ff;
      addr_lo_in   = addr_lo_ff;
      bad_fam_in   = bad_fam_ff;
      lane         = 3'd0;
      result       = '0;

      if (fire) begin
         if (in_header) begin
            if (pos_ff < 17'd2) begin
               msg_kind_in = {msg_kind_ff[7:0], b};
            end else if (pos_ff < 17'd4) begin
               body_len_in = {body_len_ff[7:0], b};
            end else if (pos_ff >= 17'd8) begin
               if (id_want != b) begin
                  id_match_in = 1'b0;
               end
            end
         end else if (in_body) begin
            if (attr_off_ff < 17'd2) begin
               attr_kind_in = {attr_kind_ff[7:0], b};
            end else if (attr_off_ff < 17'd4) begin
               attr_len_in = {attr_len_ff[7:0], b};
            end else if (value_idx < {1'b0, attr_len_ff} && attr_kind_ff == cfg.attr_code) begin
               if (value_idx == 17'd1) begin
                  // family byte opens a fresh decode, last attribute wins, but an unknown family stays flagged
                  if (b == 8'd1) begin
                     family_in  = FAMILY_IPV4;
                     port_in    = PORT_MASK;
                     addr_hi_in = '0;
                     addr_lo_in = {32'd0, COOKIE};
                  end else if (b == 8'd2) begin
                     family_in  = FAMILY_IPV6;
                     port_in    = PORT_MASK;
                     addr_hi_in = {COOKIE, cfg.id_upper};
                     addr_lo_in = cfg.id_lower;
                  end else begin
                     family_in  = FAMILY_NONE;
                     bad_fam_in = 1'b1;
                  end
               end else if (value_idx >= 17'd2 && family_ff != FAMILY_NONE) begin
                  if (value_idx == 17'd2) begin
                     port_in = port_ff ^ {b, 8'h00};
                  end else if (value_idx == 17'd3) begin
                     port_in = port_ff ^ {8'h00, b};
                  end else if (family_ff == FAMILY_IPV4) begin
                     lane = ~value_idx[2:0];
                     if (value_idx < 17'd8) begin
                        addr_lo_in = addr_lo_ff ^ (64'(b) << {lane, 3'b000});
                     end
                  end else begin
                     lane = 3'd3 - value_idx[2:0];
                     if (value_idx < 17'd12) begin
                        addr_hi_in = addr_hi_ff ^ (64'(b) << {lane, 3'b000});
                     end else if (value_idx < 17'd20) begin
                        addr_lo_in = addr_lo_ff ^ (64'(b) << {lane, 3'b000});
                     end
                  end
               end
            end
            // end of record: header plus value rounded up to four bytes
            if (attr_off_ff >= 17'd3 &&
                ({1'b0, attr_off_ff} + 18'd1) >= (18'd4 + {1'b0, len_round})) begin
               attr_off_in  = '0;
               attr_kind_in = '0;
               attr_len_in  = '0;
            end else begin
               attr_off_in = attr_off_ff + 17'd1;
            end
         end
         if (pos_ff != POS_SAT) begin
            pos_in = pos_ff + 17'd1;
         end
      end

      if (pos_in < HEADER_LEN) begin
         result.outcome = OUTCOME_LENGTH_MISMATCH;
      end else if (!id_match_in) begin
         result.outcome = OUTCOME_ID_MISMATCH;
      end else if (msg_kind_in != cfg.success_type) begin
         result.outcome = OUTCOME_NOT_SUCCESS;
      end else if (pos_in != (HEADER_LEN + {1'b0, body_len_in})) begin
         result.outcome = OUTCOME_LENGTH_MISMATCH;
      end else if (bad_fam_in) begin
         result.outcome = OUTCOME_UNKNOWN_FAMILY;
      end else begin
         result.outcome = OUTCOME_OK;
      end
      if (result.outcome == OUTCOME_OK && family_in != FAMILY_NONE) begin
         result.family    = family_in;
         result.port      = port_in;
         result.addr_high = addr_hi_in;
         result.addr_low  = addr_lo_in;
      end

      if (fire && word.last) begin
         pos_in       = '0;
         body_len_in  = '0;
         msg_kind_in  = '0;
         id_match_in  = 1'b1;
         attr_kind_in = '0;
         attr_len_in  = '0;
         attr_off_in  = '0;
         family_in    = FAMILY_NONE;
         port_in      = '0;
         addr_hi_in   = '0;
         addr_lo_in   = '0;
         bad_fam_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         body_len_ff  <= '0;
         msg_kind_ff  <= '0;
         id_match_ff  <= 1'b1;
         attr_kind_ff <= '0;
         attr_len_ff  <= '0;
         attr_off_ff  <= '0;
         family_ff    <= FAMILY_NONE;
         port_ff      <= '0;
         addr_hi_ff   <= '0;
         addr_lo_ff   <= '0;
         bad_fam_ff   <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         body_len_ff  <= body_len_in;
         msg_kind_ff  <= msg_kind_in;
         id_match_ff  <= id_match_in;
         attr_kind_ff <= attr_kind_in;
         attr_len_ff  <= attr_len_in;
         attr_off_ff  <= attr_off_in;
         family_ff    <= family_in;
         port_ff      <= port_in;
         addr_hi_ff   <= addr_hi_in;
         addr_lo_ff   <= addr_lo_in;
         bad_fam_ff   <= bad_fam_in;
      end
   end

endmodule

// ----- src/smap_out_stage.sv -----
module smap_out_stage
   import smap_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       slot_free,
   output logic       out_valid,
   input  logic       out_ready,
   output result_type out_result
);

   logic       valid_ff;
   logic       valid_in;
   result_type result_ff;

   assign slot_free = !valid_ff || out_ready;
   assign valid_in  = load ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ----- src/stun_mapped_address_parser.sv -----
// STUN binding response parser. Datagram bytes enter one word per cycle on
// the req_ channel, with req_final_byte marking the last byte; that last
// word yields exactly one result on the rsp_ channel, all other words none.
// The 20-byte header is checked (message type against success_type,
// transaction ID against the expected ID registers) and the body is walked
// as type/length/value attributes padded to four bytes; the attribute whose
// type equals mapped_attr_code is decoded as an XOR-mapped IPv4 or IPv6
// address, the last such attribute winning. Outcome priority: short
// datagram, ID mismatch, wrong type, byte count versus length field,
// unknown family, ok; address fields read zero unless the outcome is ok.
// Throughput is one byte per cycle sustained: each byte passes an input
// register, the parser update logic and a result register, so a result
// is loaded into the result register as its final byte leaves the input
// register. Input stalls only while a finished result waits in the
// result register and the next final byte reaches the parser. Configuration
// is written through the csr_ port and must only change while no datagram
// is in flight.
module stun_mapped_address_parser
   import smap_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_response_byte,
   input  logic        req_final_byte,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_outcome,
   output logic [1:0]  rsp_addr_family,
   output logic [15:0] rsp_mapped_port,
   output logic [63:0] rsp_mapped_addr_high,
   output logic [63:0] rsp_mapped_addr_low,

   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_write_data
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   word_type   req_word;
   word_type   s1_word;
   logic       s1_valid;
   logic       advance;
   logic       fire;
   logic       slot_free;
   result_type result;
   result_type rsp_result;

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_ID_UPPER:  cfg_in.id_upper     = csr_write_data[31:0];
            CSR_ID_LOWER:  cfg_in.id_lower     = csr_write_data;
            CSR_ATTR_CODE: cfg_in.attr_code    = csr_write_data[15:0];
            CSR_SUCCESS:   cfg_in.success_type = csr_write_data[15:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.id_upper     <= '0;
         cfg_ff.id_lower     <= '0;
         cfg_ff.attr_code    <= 16'd32;
         cfg_ff.success_type <= 16'd257;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_word.data = req_response_byte;
   assign req_word.last = req_final_byte;

   // a non-final word always moves on; a final one needs the result slot
   assign advance = !s1_word.last || slot_free;
   assign fire    = s1_valid && advance;

   smap_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_word),
      .advance   (advance),
      .out_valid (s1_valid),
      .out_word  (s1_word)
   );

   smap_parser u_parser (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg_ff),
      .fire   (fire),
      .word   (s1_word),
      .result (result)
   );

   smap_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (fire && s1_word.last),
      .result     (result),
      .slot_free  (slot_free),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_result (rsp_result)
   );

   assign rsp_outcome          = rsp_result.outcome;
   assign rsp_addr_family      = rsp_result.family;
   assign rsp_mapped_port      = rsp_result.port;
   assign rsp_mapped_addr_high = rsp_result.addr_high;
   assign rsp_mapped_addr_low  = rsp_result.addr_low;

endmodule
